// File: rtl/seven_segment_display_writer_top_defines.svh
// ----------------------------------------------------------------------------
// Seven-segment display writer: assertion macros
// Shared property forms for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_DISPLAY_WRITER_TOP_DEFINES_SVH
`define SEVEN_SEGMENT_DISPLAY_WRITER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low
`define SSDW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define SSDW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ssdw_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment display writer package
// Transaction types, bus addresses, segment table and state word.
// ----------------------------------------------------------------------------
package ssdw_pkg;

    typedef enum logic [1:0] {
        OP_CHAR,
        OP_NUMBER,
        OP_ENABLE,
        OP_BRIGHT
    } opcode_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [7:0]  char_code;
        logic [15:0] number_value;
        logic        enable_on;
        logic [2:0]  brightness_level;
    } cmd_item_t;

    typedef struct packed {
        logic [6:0] bus_address;
        logic [7:0] bus_data;
        logic       last_write;
        logic       display_enabled;
    } bus_item_t;

    // Persistent display state, held in the state RAM
    typedef struct packed {
        logic       enabled;
        logic [2:0] cursor;
    } state_t;

    typedef struct packed {
        logic active;
        logic emit;
        logic done;
    } seq_status_t;

    localparam logic [6:0]  CTRL_ADDR   = 7'h24;
    localparam logic [6:0]  DIGIT0_ADDR = 7'h34;
    localparam logic [6:0]  DIGIT3_ADDR = 7'h37;
    localparam logic [7:0]  SEG_E       = 8'h79;
    localparam logic [7:0]  CHAR_NUL    = 8'd0;
    localparam logic [7:0]  CHAR_CR     = 8'd13;
    localparam logic [7:0]  CHAR_FIRST  = 8'd32;
    localparam logic [7:0]  CHAR_LAST   = 8'd127;
    localparam logic [15:0] NUMBER_MAX  = 16'd9999;
    localparam logic [6:0]  DIGIT_BASE  = 7'd16;
    localparam int          NUM_W       = 14;
    // floor(v * 6554 / 65536) == floor(v / 10) for v up to 9999
    localparam logic [12:0] RECIP_10    = 13'd6554;
    localparam logic [7:0]  ENABLE_ON   = 8'h01;

    localparam logic [7:0] SEG_TABLE [96] = '{
        8'h00, 8'h82, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
        8'h39, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h40, 8'h80, 8'h00,
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h48, 8'h00, 8'h53,
        8'h00, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h6F,
        8'h76, 8'h06, 8'h1E, 8'h00, 8'h38, 8'h00, 8'h54, 8'h3F,
        8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h3E, 8'h00, 8'h00,
        8'h00, 8'h6E, 8'h00, 8'h39, 8'h00, 8'h0F, 8'h00, 8'h08,
        8'h63, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F,
        8'h74, 8'h02, 8'h1E, 8'h00, 8'h06, 8'h00, 8'h54, 8'h5C,
        8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h00, 8'h00,
        8'h00, 8'h6E, 8'h00, 8'h39, 8'h30, 8'h0F, 8'h00, 8'h00
    };

    function automatic logic [7:0] char_pattern(input logic [7:0] code);
        logic [7:0] idx;
        idx = code - CHAR_FIRST;
        if (code < CHAR_FIRST || code > CHAR_LAST)
            return 8'h00;
        return SEG_TABLE[idx[6:0]];
    endfunction

    function automatic logic [7:0] digit_pattern(input logic [3:0] d);
        logic [6:0] idx;
        idx = DIGIT_BASE + {3'b000, d};
        return SEG_TABLE[idx];
    endfunction

endpackage

// File: rtl/ssdw_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ssdw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read-old on a same-address collision
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/ssdw_seq.sv
// ----------------------------------------------------------------------------
// Write sequencer
// Holds one command and steps out its bus writes, one digit per cycle unless stalled.
// ----------------------------------------------------------------------------
module ssdw_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  ssdw_pkg::cmd_item_t   cmd_item,
    input  ssdw_pkg::state_t      cur_state,
    input  logic                  out_ready,
    output ssdw_pkg::seq_status_t status,
    output ssdw_pkg::bus_item_t   bus_item,
    output ssdw_pkg::state_t      next_state
);

    import ssdw_pkg::*;

    logic              active_reg;
    logic [1:0]        step_reg;
    cmd_item_t         cmd_reg;
    logic [NUM_W-1:0]  val_reg;

    logic              emit;
    logic              last;
    logic              is_cr;
    logic              home;
    logic [2:0]        cur_eff;
    logic              big;
    logic [26:0]       prod;
    logic [9:0]        quot;
    logic [NUM_W-1:0]  quot_x10;
    logic [NUM_W-1:0]  rem;

    // one decimal digit per step
    assign prod     = 27'(val_reg) * 27'(RECIP_10);
    assign quot     = prod[25:16];
    assign quot_x10 = NUM_W'(quot) * NUM_W'(10);
    assign rem      = val_reg - quot_x10;
    assign big      = cmd_reg.number_value > NUMBER_MAX;

    assign is_cr   = cmd_reg.char_code == CHAR_CR;
    assign home    = cur_state.cursor > 3'd3 || is_cr || cmd_reg.char_code == CHAR_NUL;
    assign cur_eff = home ? 3'd0 : cur_state.cursor;

    always_comb
    begin
        emit       = 1'b0;
        last       = 1'b1;
        next_state = cur_state;
        bus_item   = '0;
        case (cmd_reg.opcode)
            OP_CHAR:
            begin
                next_state.cursor = 3'd0;
                if (!is_cr)
                begin
                    emit                 = 1'b1;
                    bus_item.bus_address = DIGIT0_ADDR + {5'b00000, cur_eff[1:0]};
                    bus_item.bus_data    = char_pattern(cmd_reg.char_code);
                    next_state.cursor    = cur_eff + 3'd1;
                end
            end
            OP_NUMBER:
            begin
                emit = 1'b1;
                last = step_reg == 2'd3;
                if (big)
                begin
                    bus_item.bus_address = DIGIT0_ADDR + {5'b00000, step_reg};
                    bus_item.bus_data    = SEG_E;
                end
                else
                begin
                    bus_item.bus_address = DIGIT3_ADDR - {5'b00000, step_reg};
                    bus_item.bus_data    = digit_pattern(rem[3:0]);
                end
            end
            OP_ENABLE:
            begin
                emit                 = 1'b1;
                bus_item.bus_address = CTRL_ADDR;
                bus_item.bus_data    = cmd_reg.enable_on ? ENABLE_ON : 8'h00;
                next_state.enabled   = cmd_reg.enable_on;
            end
            OP_BRIGHT:
            begin
                emit                 = 1'b1;
                bus_item.bus_address = CTRL_ADDR;
                bus_item.bus_data    = {1'b0, cmd_reg.brightness_level, 4'b0000};
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        bus_item.last_write      = last;
        bus_item.display_enabled = next_state.enabled;

        status.active = active_reg;
        status.emit   = active_reg & emit;
        // a carriage return finishes without a write
        status.done   = active_reg & (emit ? (out_ready & last) : 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= 2'd0;
        end
        else if (accept)
        begin
            active_reg <= 1'b1;
            step_reg   <= 2'd0;
        end
        else if (status.done)
        begin
            active_reg <= 1'b0;
        end
        else if (status.emit && out_ready)
        begin
            step_reg <= step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_item;
            val_reg <= cmd_item.number_value[NUM_W-1:0];
        end
        else if (status.emit && out_ready)
        begin
            // advance to the next decimal digit
            val_reg <= NUM_W'(quot);
        end
    end

endmodule

// File: rtl/seven_segment_display_writer_top.sv
// Seven-segment display writer, four digits.
// Command channel (cmd_valid / cmd_stall / cmd_item): one transaction per
// command: character, number, enable or brightness.
// Bus channel (bus_valid / bus_stall / bus_item): one transaction per
// display-chip write, address and data byte; last_write marks the final
// write of a command. A carriage return yields no bus transaction.
// The first write of a command passes through the sequencer's command register
// and then the bus output register before it is presented on the bus.
// A number command makes four writes (one decimal digit per cycle through
// the sequencer's reciprocal multiplier, while the bus does not stall); every
// other command makes at most one. The next command is accepted in the cycle
// the previous one finishes, so commands run back to back.
// Cursor and enabled flag live in word 0 of a two-word state RAM, read as a
// command is accepted and written back when it finishes; a write-back that
// coincides with the next read is forwarded.
// Reset: cursor 0, display off, no transaction pending.
// A stall on the bus holds the output register; the sequencer then halts, and
// cmd_stall stays high until the final write is loaded into that register.
// ----------------------------------------------------------------------------
// Seven-segment display writer top level
// Command intake, state RAM with forwarding, sequencer and bus register.
// ----------------------------------------------------------------------------
`include "seven_segment_display_writer_top_defines.svh"

module seven_segment_display_writer_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  ssdw_pkg::cmd_item_t cmd_item,
    output logic                bus_valid,
    input  logic                bus_stall,
    output ssdw_pkg::bus_item_t bus_item
);

    import ssdw_pkg::*;

    localparam int STATE_W     = $bits(state_t);
    localparam int STATE_DEPTH = 2;

    logic          accept;
    logic          out_ready;
    logic          load;
    seq_status_t   status;
    bus_item_t     seq_item;
    state_t        next_state;
    state_t        cur_state;
    logic [STATE_W-1:0] rd_data;

    logic          state_valid_reg;
    logic          fwd_valid_reg;
    state_t        fwd_reg;
    logic          bus_valid_reg;
    bus_item_t     bus_item_reg;

    assign accept    = cmd_valid & ~cmd_stall;
    assign cmd_stall = status.active & ~status.done;
    assign out_ready = ~bus_valid_reg | ~bus_stall;
    assign load      = status.emit & out_ready;

    ssdw_ram #(
        .WIDTH (STATE_W),
        .DEPTH (STATE_DEPTH)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (status.done),
        .wr_addr (1'b0),
        .wr_data (next_state),
        .rd_en   (accept),
        .rd_addr (1'b0),
        .rd_data (rd_data)
    );

    // Take the write-back that landed on the read edge; an unwritten word reads as reset
    assign cur_state = fwd_valid_reg   ? fwd_reg :
                       state_valid_reg ? state_t'(rd_data) : '0;

    ssdw_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .cmd_item   (cmd_item),
        .cur_state  (cur_state),
        .out_ready  (out_ready),
        .status     (status),
        .bus_item   (seq_item),
        .next_state (next_state)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_valid_reg <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            bus_valid_reg   <= 1'b0;
        end
        else
        begin
            if (status.done)
            begin
                state_valid_reg <= 1'b1;
            end
            if (accept)
            begin
                fwd_valid_reg <= status.done;
            end
            if (out_ready)
            begin
                bus_valid_reg <= status.emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.done)
        begin
            fwd_reg <= next_state;
        end
        if (load)
        begin
            bus_item_reg <= seq_item;
        end
    end

    assign bus_valid = bus_valid_reg;
    assign bus_item  = bus_item_reg;

    `SSDW_ASSERT_NEXT(a_more_writes, load && !seq_item.last_write, status.active, "sequencer dropped a command before its final write")
    `SSDW_ASSERT_NOW(a_fwd_implies_written, fwd_valid_reg, state_valid_reg, "forwarded state without any write-back")
    `SSDW_ASSERT_NOW(a_bus_address, bus_valid_reg, bus_item_reg.bus_address == CTRL_ADDR || (bus_item_reg.bus_address >= DIGIT0_ADDR && bus_item_reg.bus_address <= DIGIT3_ADDR), "bus write to an address outside the display chip")

endmodule

// File: tb/sv/tb_seven_segment_display_writer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Seven-segment display writer testbench
// Drives character, number, enable and brightness commands and checks every
// bus write against typed table writes or an in-bench prediction of cursor,
// enable flag and segment patterns. A short directed table comes first, then
// random commands under several mixes of sender gaps and bus stalls.
// ----------------------------------------------------------------------------
module tb_seven_segment_display_writer_top;
    import ssdw_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         DRAIN_CYCLES = 10;
    localparam logic [6:0] CTRL = 7'h24;
    localparam logic [6:0] DIG0 = 7'h34;
    localparam logic [6:0] DIG1 = 7'h35;
    localparam logic [6:0] DIG2 = 7'h36;
    localparam logic [6:0] DIG3 = 7'h37;
    localparam logic [7:0] GLYPH_E = 8'h79;
    localparam logic [7:0] ASCII_NUL = 8'd0;
    localparam logic [7:0] ASCII_CR = 8'd13;
    localparam logic [7:0] ASCII_FIRST = 8'd32;
    localparam logic [7:0] ASCII_LAST = 8'd127;
    localparam logic [15:0] NUM_LIMIT = 16'd9999;

    // Segment patterns for ASCII 32..127; digits start at entry 16
    localparam logic [7:0] SEG_GLYPHS [96] = '{
        8'h00, 8'h82, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
        8'h39, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h40, 8'h80, 8'h00,
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h48, 8'h00, 8'h53,
        8'h00, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h6F,
        8'h76, 8'h06, 8'h1E, 8'h00, 8'h38, 8'h00, 8'h54, 8'h3F,
        8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h3E, 8'h00, 8'h00,
        8'h00, 8'h6E, 8'h00, 8'h39, 8'h00, 8'h0F, 8'h00, 8'h08,
        8'h63, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F,
        8'h74, 8'h02, 8'h1E, 8'h00, 8'h06, 8'h00, 8'h54, 8'h5C,
        8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h00, 8'h00,
        8'h00, 8'h6E, 8'h00, 8'h39, 8'h30, 8'h0F, 8'h00, 8'h00
    };

    // Directed command; writes typed in only where typed is set
    typedef struct packed {
        cmd_item_t        cmd;
        logic             typed;
        logic [2:0]       nres;
        logic [0:3][6:0]  addr;
        logic [0:3][7:0]  data;
        logic             en;
    } dir_row_t;

    localparam int NDIR = 25;
    localparam dir_row_t DIR_TABLE [NDIR] = '{
        '{'{OP_BRIGHT, 8'd0, 16'd0, 1'b0, 3'd7}, 1'b1, 3'd1,
          {CTRL, 21'h0}, {8'h70, 24'h0}, 1'b0},
        '{'{OP_BRIGHT, 8'hFF, 16'hFFFF, 1'b1, 3'd0}, 1'b1, 3'd1,
          {CTRL, 21'h0}, {8'h00, 24'h0}, 1'b0},
        '{'{OP_ENABLE, 8'd0, 16'd0, 1'b1, 3'd0}, 1'b1, 3'd1,
          {CTRL, 21'h0}, {8'h01, 24'h0}, 1'b1},
        '{'{OP_CHAR, 8'd48, 16'd0, 1'b0, 3'd0}, 1'b1, 3'd1,
          {DIG0, 21'h0}, {8'h3F, 24'h0}, 1'b1},
        '{'{OP_CHAR, 8'd65, 16'hFFFF, 1'b0, 3'd7}, 1'b1, 3'd1,
          {DIG1, 21'h0}, {8'h77, 24'h0}, 1'b1},
        '{'{OP_CHAR, ASCII_LAST, 16'd0, 1'b0, 3'd0}, 1'b1, 3'd1,
          {DIG2, 21'h0}, {8'h00, 24'h0}, 1'b1},
        '{'{OP_CHAR, 8'd255, 16'd0, 1'b0, 3'd0}, 1'b1, 3'd1,
          {DIG3, 21'h0}, {8'h00, 24'h0}, 1'b1},
        // cursor is past the last digit: wrap before writing
        '{'{OP_CHAR, ASCII_FIRST, 16'd0, 1'b0, 3'd0}, 1'b1, 3'd1,
          {DIG0, 21'h0}, {8'h00, 24'h0}, 1'b1},
        '{'{OP_CHAR, ASCII_CR, 16'd0, 1'b0, 3'd0}, 1'b1, 3'd0,
          28'h0, 32'h0, 1'b1},
        '{'{OP_CHAR, 8'd57, 16'd0, 1'b0, 3'd0}, 1'b1, 3'd1,
          {DIG0, 21'h0}, {8'h6F, 24'h0}, 1'b1},
        '{'{OP_CHAR, ASCII_NUL, 16'd0, 1'b0, 3'd0}, 1'b1, 3'd1,
          {DIG0, 21'h0}, {8'h00, 24'h0}, 1'b1},
        '{'{OP_CHAR, 8'd31, 16'd0, 1'b0, 3'd0}, 1'b1, 3'd1,
          {DIG1, 21'h0}, {8'h00, 24'h0}, 1'b1},
        '{'{OP_NUMBER, 8'd0, 16'd0, 1'b0, 3'd0}, 1'b1, 3'd4,
          {DIG3, DIG2, DIG1, DIG0}, {4{8'h3F}}, 1'b1},
        '{'{OP_NUMBER, 8'hFF, NUM_LIMIT, 1'b1, 3'd7}, 1'b1, 3'd4,
          {DIG3, DIG2, DIG1, DIG0}, {4{8'h6F}}, 1'b1},
        '{'{OP_NUMBER, 8'd0, 16'd10000, 1'b0, 3'd0}, 1'b1, 3'd4,
          {DIG0, DIG1, DIG2, DIG3}, {4{GLYPH_E}}, 1'b1},
        '{'{OP_NUMBER, 8'd0, 16'hFFFF, 1'b0, 3'd0}, 1'b1, 3'd4,
          {DIG0, DIG1, DIG2, DIG3}, {4{GLYPH_E}}, 1'b1},
        '{'{OP_NUMBER, 8'd0, 16'd1234, 1'b0, 3'd0}, 1'b0, 3'd0, 28'h0, 32'h0, 1'b0},
        '{'{OP_ENABLE, 8'hFF, 16'hFFFF, 1'b0, 3'd7}, 1'b1, 3'd1,
          {CTRL, 21'h0}, {8'h00, 24'h0}, 1'b0},
        '{'{OP_CHAR, 8'd122, 16'd0, 1'b0, 3'd0}, 1'b0, 3'd0, 28'h0, 32'h0, 1'b0},
        '{'{OP_CHAR, 8'd45, 16'd0, 1'b0, 3'd0}, 1'b0, 3'd0, 28'h0, 32'h0, 1'b0},
        '{'{OP_CHAR, 8'd72, 16'd0, 1'b0, 3'd0}, 1'b0, 3'd0, 28'h0, 32'h0, 1'b0},
        '{'{OP_ENABLE, 8'd0, 16'd0, 1'b1, 3'd0}, 1'b0, 3'd0, 28'h0, 32'h0, 1'b0},
        '{'{OP_NUMBER, 8'd0, 16'd9, 1'b0, 3'd0}, 1'b0, 3'd0, 28'h0, 32'h0, 1'b0},
        '{'{OP_NUMBER, 8'd0, 16'd1000, 1'b0, 3'd0}, 1'b0, 3'd0, 28'h0, 32'h0, 1'b0},
        '{'{OP_BRIGHT, 8'h5A, 16'hA5A5, 1'b1, 3'd5}, 1'b0, 3'd0, 28'h0, 32'h0, 1'b0}
    };

    logic       clk;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_stall;
    cmd_item_t  cmd_item;
    logic       bus_valid;
    logic       bus_stall = 1'b0;
    bus_item_t  bus_item;

    // Predicted display state
    logic [2:0] digit_cursor = 3'd0;
    logic       display_on = 1'b0;

    bus_item_t  expected_writes [$];
    bus_item_t  want;
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         send_idle_pct = 0;
    int         bus_stall_pct = 0;

    seven_segment_display_writer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .bus_valid (bus_valid),
        .bus_stall (bus_stall),
        .bus_item  (bus_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Work out the bus writes of one command and advance the display state
    function automatic int predict_writes(input cmd_item_t c, output bus_item_t [0:3] w);
        int         n;
        int         k;
        logic [15:0] v;
        n = 0;
        w = '0;
        case (c.opcode)
            OP_CHAR:
            begin
                if (digit_cursor > 3'd3 || c.char_code == ASCII_CR || c.char_code == ASCII_NUL)
                    digit_cursor = 3'd0;
                if (c.char_code != ASCII_CR)
                begin
                    w[0].bus_address = DIG0 + {5'b0, digit_cursor[1:0]};
                    if (c.char_code < ASCII_FIRST || c.char_code > ASCII_LAST)
                        w[0].bus_data = 8'h00;
                    else
                        w[0].bus_data = SEG_GLYPHS[c.char_code - ASCII_FIRST];
                    digit_cursor = digit_cursor + 3'd1;
                    n = 1;
                end
            end
            OP_NUMBER:
            begin
                v = c.number_value;
                for (k = 0; k < 4; k++)
                begin
                    if (c.number_value > NUM_LIMIT)
                    begin
                        w[k].bus_address = DIG0 + 7'(k);
                        w[k].bus_data = GLYPH_E;
                    end
                    else
                    begin
                        // lowest digit goes to the rightmost register
                        w[k].bus_address = DIG3 - 7'(k);
                        w[k].bus_data = SEG_GLYPHS[16 + v % 10];
                        v = v / 10;
                    end
                end
                n = 4;
            end
            OP_ENABLE:
            begin
                w[0].bus_address = CTRL;
                w[0].bus_data = {7'b0, c.enable_on};
                display_on = c.enable_on;
                n = 1;
            end
            default:
            begin
                w[0].bus_address = CTRL;
                w[0].bus_data = {1'b0, c.brightness_level, 4'b0};
                n = 1;
            end
        endcase
        for (k = 0; k < n; k++)
        begin
            w[k].last_write = (k == n - 1);
            w[k].display_enabled = display_on;
        end
        return n;
    endfunction

    function automatic cmd_item_t random_cmd();
        cmd_item_t c;
        int        pick;
        pick = $urandom_range(9);
        if (pick < 5)
            c.opcode = OP_CHAR;
        else if (pick < 7)
            c.opcode = OP_NUMBER;
        else if (pick < 8)
            c.opcode = OP_ENABLE;
        else
            c.opcode = OP_BRIGHT;
        pick = $urandom_range(11);
        case (pick)
            0:       c.char_code = ASCII_NUL;
            1, 2:    c.char_code = ASCII_CR;
            3:       c.char_code = 8'($urandom_range(31));
            4:       c.char_code = 8'($urandom_range(255, 128));
            default: c.char_code = 8'($urandom_range(127, 32));
        endcase
        pick = $urandom_range(9);
        if (pick < 6)
            c.number_value = 16'($urandom_range(9999));
        else if (pick < 7)
            c.number_value = 16'($urandom_range(99));
        else if (pick < 9)
            c.number_value = 16'($urandom_range(65535, 10000));
        else
            c.number_value = ($urandom_range(1) != 0) ? NUM_LIMIT : NUM_LIMIT + 16'd1;
        c.enable_on = 1'($urandom_range(1));
        c.brightness_level = 3'($urandom_range(7));
        return c;
    endfunction

    // Present one command, wait for its transaction and queue its writes.
    // Called and left at a falling edge.
    task automatic send_cmd(input cmd_item_t c, input int typed_n,
                            input bus_item_t [0:3] typed_w);
        bus_item_t [0:3] w;
        int              n;
        int              k;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            cmd_item  <= random_cmd();
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        n = predict_writes(c, w);
        if (typed_n >= 0)
        begin
            n = typed_n;
            w = typed_w;
        end
        for (k = 0; k < n; k++)
            expected_writes.push_back(w[k]);
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input int got, input int wanted);
        $display("ERROR cycle %0d: %s: got 0x%0h, expected 0x%0h", cycle_count, what, got,
                 wanted);
        mismatch_count++;
    endtask

    always @(negedge clk)
        bus_stall <= ($urandom_range(99) < bus_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && bus_valid && !bus_stall)
        begin
            if (expected_writes.size() == 0)
                report_mismatch("unexpected bus write, address", bus_item.bus_address, 0);
            else
            begin
                want = expected_writes.pop_front();
                if (bus_item.bus_address !== want.bus_address)
                    report_mismatch("bus_address", bus_item.bus_address, want.bus_address);
                if (bus_item.bus_data !== want.bus_data)
                    report_mismatch("bus_data", bus_item.bus_data, want.bus_data);
                if (bus_item.last_write !== want.last_write)
                    report_mismatch("last_write", bus_item.last_write, want.last_write);
                if (bus_item.display_enabled !== want.display_enabled)
                    report_mismatch("display_enabled", bus_item.display_enabled,
                                    want.display_enabled);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("seven_segment_display_writer_top: mismatch");
            $finish;
        end
    end

    initial
    begin
        dir_row_t        row;
        bus_item_t [0:3] typed_w;
        int              i;
        int              k;
        int              phase;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_item  = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < NDIR; i++)
        begin
            row = DIR_TABLE[i];
            for (k = 0; k < 4; k++)
            begin
                typed_w[k].bus_address = row.addr[k];
                typed_w[k].bus_data = row.data[k];
                typed_w[k].last_write = (k == int'(row.nres) - 1);
                typed_w[k].display_enabled = row.en;
            end
            send_cmd(row.cmd, row.typed ? int'(row.nres) : -1, typed_w);
        end

        // no idling, sender gaps, bus stalls, then both
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  bus_stall_pct = 0;  end
                1:       begin send_idle_pct = 82; bus_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  bus_stall_pct = 82; end
                default: begin send_idle_pct = 25; bus_stall_pct = 25; end
            endcase
            repeat (21)
                send_cmd(random_cmd(), -1, '0);
        end
        cmd_valid <= 1'b0;

        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("seven_segment_display_writer_top: match");
        else
            $display("seven_segment_display_writer_top: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ssdw_pkg.sv
rtl/ssdw_ram.sv
rtl/ssdw_seq.sv
rtl/seven_segment_display_writer_top.sv
tb/sv/tb_seven_segment_display_writer_top.sv
